### rtl/ffba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types and constants for the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

    // Table depth default; the top level carries it as a parameter.
    localparam int MAX_BLOCKS_DEF = 64;

    // Header ahead of every block's user data (a multiple of 16 bytes).
    localparam logic [31:0] HEADER_BYTES = 32'd32;

    // Register reset values
    localparam logic [31:0] HEAP_BASE_RST  = 32'd65536;
    localparam logic [31:0] HEAP_LIMIT_RST = 32'd1048576;

    // Field widths
    localparam int ADDR_W = 32;
    localparam int SIZE_W = 24;
    localparam int STAT_W = 3;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_HEAP_BASE  = 1'b0,
        CFG_HEAP_LIMIT = 1'b1
    } cfg_idx_t;

    typedef enum logic [0:0] {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_REUSED   = 3'd0,
        STAT_EXTENDED = 3'd1,
        STAT_OOM      = 3'd2,
        STAT_FREED    = 3'd3,
        STAT_NULL     = 3'd4,
        STAT_UNKNOWN  = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_MISS,
        S_DONE
    } fsm_state_t;

    // One table entry as stored in memory
    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [SIZE_W-1:0] size;
        logic              is_free;
    } entry_t;

    // Configuration seen by the engine
    typedef struct packed {
        logic              base_we;
        logic [ADDR_W-1:0] base_value;
        logic [ADDR_W-1:0] limit;
    } cfg_t;

    // Result handed from the engine to the output register
    typedef struct packed {
        logic [ADDR_W-1:0] user_address;
        status_t           status;
    } res_t;

endpackage

### rtl/ffba_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module ffba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, registered
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/ffba_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_engine
// Block table sequencer: walks the table in memory one entry per cycle,
// marks hits, appends new blocks at the heap top and keeps count and top.
// ----------------------------------------------------------------------------
module ffba_engine #(
    parameter int MAX_BLOCKS = ffba_pkg::MAX_BLOCKS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  ffba_pkg::cfg_t                 cfg,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           in_opcode,
    input  logic [ffba_pkg::SIZE_W-1:0]    in_request_size,
    input  logic [ffba_pkg::ADDR_W-1:0]    in_free_address,
    output logic                           res_valid,
    input  logic                           res_ready,
    output ffba_pkg::res_t                 res
);

    import ffba_pkg::*;

    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int ENT_W = $bits(entry_t);

    fsm_state_t          state_reg, state_next;
    op_t                 op_reg, op_next;
    logic [SIZE_W-1:0]   req_reg, req_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [ADDR_W-1:0]   heap_top_reg, heap_top_next;
    res_t                res_reg, res_next;

    logic                ram_wr_en, ram_rd_en;
    logic [IDX_W-1:0]    ram_wr_addr, ram_rd_addr;
    entry_t              ram_wr_data, ram_rd_entry;
    logic [ENT_W-1:0]    ram_rd_data;

    logic                hit;
    logic [CNT_W-1:0]    idx_inc;
    logic [ADDR_W+1:0]   new_top;
    logic                table_full;
    logic                ext_ok;

    // Table memory. Writes happen only on a hit in S_WALK or an append in
    // S_MISS; the next read comes from S_IDLE after S_DONE, so no forwarding.
    ffba_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_BLOCKS)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign ram_rd_entry = entry_t'(ram_rd_data);

    // Match on the entry read last cycle
    always_comb begin
        if (op_reg == OP_ALLOC) begin
            hit = ram_rd_entry.is_free && (ram_rd_entry.size >= req_reg);
        end else begin
            hit = ((ram_rd_entry.start + HEADER_BYTES) == addr_reg);
        end
    end

    assign idx_inc    = CNT_W'(idx_reg) + CNT_W'(1);
    assign new_top    = {2'b00, heap_top_reg} + {2'b00, HEADER_BYTES}
                        + (ADDR_W+2)'(req_reg);
    assign table_full = (count_reg == CNT_W'(MAX_BLOCKS));
    assign ext_ok     = !table_full && (new_top <= {2'b00, cfg.limit});

    // State register and datapath registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            heap_top_reg <= HEAP_BASE_RST;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            heap_top_reg <= heap_top_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg   <= op_next;
        req_reg  <= req_next;
        addr_reg <= addr_next;
        idx_reg  <= idx_next;
        res_reg  <= res_next;
    end

    // Next state and outputs
    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        req_next      = req_reg;
        addr_next     = addr_reg;
        idx_next      = idx_reg;
        count_next    = count_reg;
        heap_top_next = heap_top_reg;
        res_next      = res_reg;
        in_ready      = 1'b0;
        res_valid     = 1'b0;
        ram_rd_en     = 1'b0;
        ram_rd_addr   = '0;
        ram_wr_en     = 1'b0;
        ram_wr_addr   = idx_reg;
        ram_wr_data   = ram_rd_entry;

        // Base rewrite reloads the top only while the table is empty
        if (cfg.base_we && (count_reg == '0)) begin
            heap_top_next = cfg.base_value;
        end

        unique case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    op_next   = op_t'(in_opcode);
                    req_next  = in_request_size;
                    addr_next = in_free_address;
                    idx_next  = '0;
                    if ((op_t'(in_opcode) == OP_FREE) && (in_free_address == '0)) begin
                        res_next   = '{user_address: '0, status: STAT_NULL};
                        state_next = S_DONE;
                    end else if (count_reg == '0) begin
                        if (op_t'(in_opcode) == OP_ALLOC) begin
                            state_next = S_MISS;
                        end else begin
                            res_next   = '{user_address: '0, status: STAT_UNKNOWN};
                            state_next = S_DONE;
                        end
                    end else begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = '0;
                        state_next  = S_WALK;
                    end
                end
            end

            S_WALK: begin
                if (hit) begin
                    // Write back the matched entry with its new free flag
                    ram_wr_en           = 1'b1;
                    ram_wr_addr         = idx_reg;
                    ram_wr_data         = ram_rd_entry;
                    ram_wr_data.is_free = (op_reg == OP_FREE);
                    if (op_reg == OP_ALLOC) begin
                        res_next = '{user_address: ram_rd_entry.start + HEADER_BYTES,
                                     status: STAT_REUSED};
                    end else begin
                        res_next = '{user_address: '0, status: STAT_FREED};
                    end
                    state_next = S_DONE;
                end else if (idx_inc < count_reg) begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = idx_inc[IDX_W-1:0];
                    idx_next    = idx_inc[IDX_W-1:0];
                end else if (op_reg == OP_ALLOC) begin
                    state_next = S_MISS;
                end else begin
                    res_next   = '{user_address: '0, status: STAT_UNKNOWN};
                    state_next = S_DONE;
                end
            end

            S_MISS: begin
                if (ext_ok) begin
                    // Append at the heap top
                    ram_wr_en     = 1'b1;
                    ram_wr_addr   = count_reg[IDX_W-1:0];
                    ram_wr_data   = '{start: heap_top_reg, size: req_reg, is_free: 1'b0};
                    count_next    = count_reg + CNT_W'(1);
                    heap_top_next = new_top[ADDR_W-1:0];
                    res_next      = '{user_address: heap_top_reg + HEADER_BYTES,
                                      status: STAT_EXTENDED};
                end else begin
                    res_next = '{user_address: '0, status: STAT_OOM};
                end
                state_next = S_DONE;
            end

            S_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res = res_reg;

    // Assertions
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_BLOCKS))
        else $error("block count above table depth");

    a_walk_in_table: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WALK) |-> (CNT_W'(idx_reg) < count_reg))
        else $error("table walk beyond block count");

    a_extend_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MISS && ext_ok) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("extension did not grow the table");

    a_write_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_wr_en |-> !ram_rd_en && (state_reg == S_WALK || state_reg == S_MISS))
        else $error("table write outside walk or extension");

endmodule

### rtl/first_fit_block_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit heap allocator over a block table held in a synchronous RAM.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Handshake            | Payload
//  s_       | in        | s_valid / s_ready    | s_opcode, s_request_size,
//           |           |                      | s_free_address
//  m_       | out       | m_valid / m_ready    | m_user_address, m_status
//  cfg_     | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  One transaction is in work at a time. Allocate and free walk the table
//  one entry per cycle through the RAM read port; an allocate that misses
//  extends the heap, unless the table is full or the limit would be
//  passed. A null free skips the walk. The result sits in an output
//  register; a stalled m_ready holds the engine in its done state. No
//  clearing pass: reset empties the table by zeroing the block count.
//  Configuration writes are always taken.
// ----------------------------------------------------------------------------
module first_fit_block_allocator #(
    parameter int MAX_BLOCKS = ffba_pkg::MAX_BLOCKS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Request channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_opcode,
    input  logic [ffba_pkg::SIZE_W-1:0]   s_request_size,
    input  logic [ffba_pkg::ADDR_W-1:0]   s_free_address,
    // Result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [ffba_pkg::ADDR_W-1:0]   m_user_address,
    output logic [ffba_pkg::STAT_W-1:0]   m_status,
    // Configuration write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_index,
    input  logic [ffba_pkg::ADDR_W-1:0]   cfg_data
);

    import ffba_pkg::*;

    logic              cfg_we;
    logic [ADDR_W-1:0] heap_limit_reg;
    cfg_t              cfg;
    logic              res_valid, res_ready;
    res_t              res;
    logic              m_valid_reg;
    res_t              m_res_reg;

    // Config writes. The base only matters as a heap top load, which the
    // engine takes straight from the write.
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            heap_limit_reg <= HEAP_LIMIT_RST;
        end else if (cfg_we && (cfg_idx_t'(cfg_index) == CFG_HEAP_LIMIT)) begin
            heap_limit_reg <= cfg_data;
        end
    end

    assign cfg = '{base_we:    cfg_we && (cfg_idx_t'(cfg_index) == CFG_HEAP_BASE),
                   base_value: cfg_data,
                   limit:      heap_limit_reg};

    // Table engine
    ffba_engine #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_engine (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg),
        .in_valid        (s_valid),
        .in_ready        (s_ready),
        .in_opcode       (s_opcode),
        .in_request_size (s_request_size),
        .in_free_address (s_free_address),
        .res_valid       (res_valid),
        .res_ready       (res_ready),
        .res             (res)
    );

    // Output register
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_res_reg <= res;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_user_address = m_res_reg.user_address;
    assign m_status       = m_res_reg.status;

endmodule
